### hdl/bkp_pkg.sv
`timescale 1ns / 1ps

package bkp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int RAW_W      = 16;
   localparam int DEPTH_W    = 32;
   localparam int FOCAL_W    = 32;
   localparam int CENTER_W   = 29;
   localparam int OUT_W      = 22;
   localparam int QUO_BITS   = OUT_W;
   // one setup stage, then one quotient bit per stage
   localparam int DIV_LAT    = QUO_BITS + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   // magnitude of the most negative value; the same bits encode that value
   localparam logic [OUT_W-1:0] OUT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAW_SCALE     = 3'd0,
      CSR_MIN_DEPTH     = 3'd1,
      CSR_MAX_DEPTH     = 3'd2,
      CSR_FOCAL_X       = 3'd3,
      CSR_FOCAL_Y       = 3'd4,
      CSR_PRINCIPAL_COL = 3'd5,
      CSR_PRINCIPAL_ROW = 3'd6
   } bkp_csr_index_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]  raw_scale;
      logic [DEPTH_W-1:0]  min_depth;
      logic [DEPTH_W-1:0]  max_depth;
      logic [FOCAL_W-1:0]  focal_x;
      logic [FOCAL_W-1:0]  focal_y;
      logic [CENTER_W-1:0] principal_col;
      logic [CENTER_W-1:0] principal_row;
   } bkp_cfg_type;

   localparam bkp_cfg_type CFG_RESET = '{
      raw_scale:     32'd536871,
      min_depth:     32'd6554,
      max_depth:     32'd131072,
      focal_x:       32'd39321600,
      focal_y:       32'd39321600,
      principal_col: 29'd20971520,
      principal_row: 29'd15728640
   };

endpackage

### hdl/bkp_front.sv
`timescale 1ns / 1ps

module bkp_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bkp_pkg::bkp_cfg_type          cfg,
   input  logic                          in_push,
   output logic                          in_full,
   input  logic [COORD_BITS-1:0]         in_row,
   input  logic [COORD_BITS-1:0]         in_col,
   input  logic [bkp_pkg::RAW_W-1:0]     in_raw,
   input  logic                          q_full,
   output logic                          q_push,
   output logic [COORD_BITS-1:0]         q_row,
   output logic [COORD_BITS-1:0]         q_col,
   output logic [bkp_pkg::DEPTH_W-1:0]   q_depth
);

   localparam int PROD_W = bkp_pkg::RAW_W + bkp_pkg::DEPTH_W;

   logic                          a_valid_ff, a_valid_in;
   logic [COORD_BITS-1:0]         a_row_ff, a_col_ff;
   logic [bkp_pkg::RAW_W-1:0]     a_raw_ff;
   logic                          b_valid_ff, b_valid_in;
   logic [COORD_BITS-1:0]         b_row_ff, b_col_ff;
   logic [bkp_pkg::DEPTH_W-1:0]   b_depth_ff;
   logic [PROD_W-1:0]             a_prod;
   logic                          b_keep;
   logic                          stall;

   assign a_prod = PROD_W'(a_raw_ff) * PROD_W'(cfg.raw_scale);
   assign b_keep = (b_depth_ff > cfg.min_depth) && (b_depth_ff < cfg.max_depth);

   // hold everything while a kept pixel cannot enter the queue
   assign stall   = b_valid_ff && b_keep && q_full;
   assign in_full = stall;
   assign q_push  = b_valid_ff && b_keep && !q_full;
   assign q_row   = b_row_ff;
   assign q_col   = b_col_ff;
   assign q_depth = b_depth_ff;

   always_comb begin
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      if (!stall) begin
         a_valid_in = in_push;
         b_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         a_row_ff   <= in_row;
         a_col_ff   <= in_col;
         a_raw_ff   <= in_raw;
         b_row_ff   <= a_row_ff;
         b_col_ff   <= a_col_ff;
         b_depth_ff <= a_prod[bkp_pkg::FRAC_BITS +: bkp_pkg::DEPTH_W];
      end
   end

endmodule

### hdl/bkp_queue.sv
`timescale 1ns / 1ps

module bkp_queue #(
   parameter int WIDTH = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   logic [WIDTH-1:0]             mem_ff [bkp_pkg::QUEUE_DEPTH];
   logic [bkp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bkp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bkp_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                         do_push, do_pop;

   assign full      = (count_ff == (bkp_pkg::QUEUE_AW+1)'(bkp_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/bkp_div.sv
`timescale 1ns / 1ps

module bkp_div #(
   parameter int PROD_W = 61
) (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [bkp_pkg::FOCAL_W-1:0]        focal,
   input  logic [PROD_W-1:0]                  prod,
   input  logic                               neg,
   output logic signed [bkp_pkg::OUT_W-1:0]   result
);

   localparam int QB   = bkp_pkg::QUO_BITS;
   localparam int FW   = bkp_pkg::FOCAL_W;
   localparam int HI_W = PROD_W - QB;
   localparam int LAST = bkp_pkg::DIV_LAT - 1;

   logic [FW-1:0] rem_ff  [bkp_pkg::DIV_LAT];
   logic [FW-1:0] rem_in  [bkp_pkg::DIV_LAT];
   logic [QB-1:0] quo_ff  [bkp_pkg::DIV_LAT];
   logic [QB-1:0] quo_in  [bkp_pkg::DIV_LAT];
   logic [QB-1:0] low_ff  [bkp_pkg::DIV_LAT];
   logic [QB-1:0] low_in  [bkp_pkg::DIV_LAT];
   logic          ovf_ff  [bkp_pkg::DIV_LAT];
   logic          ovf_in  [bkp_pkg::DIV_LAT];
   logic          zero_ff [bkp_pkg::DIV_LAT];
   logic          zero_in [bkp_pkg::DIV_LAT];
   logic          neg_ff  [bkp_pkg::DIV_LAT];
   logic          neg_in  [bkp_pkg::DIV_LAT];

   logic [HI_W-1:0] prod_hi;
   logic [QB-1:0]   quo_last;

   assign prod_hi = prod[PROD_W-1:QB];

   always_comb begin
      // setup: a quotient of QB bits or more saturates either way
      zero_in[0] = (prod == '0);
      ovf_in[0]  = !zero_in[0] && (prod_hi >= HI_W'(focal));
      neg_in[0]  = neg;
      rem_in[0]  = prod_hi[FW-1:0];
      low_in[0]  = prod[QB-1:0];
      quo_in[0]  = '0;
      for (int k = 1; k < bkp_pkg::DIV_LAT; k++) begin : step
         logic [FW:0] cat;
         logic [FW:0] diff;
         logic        ge;
         cat        = {rem_ff[k-1], low_ff[k-1][QB-1]};
         diff       = cat - {1'b0, focal};
         ge         = (cat >= {1'b0, focal});
         rem_in[k]  = ge ? diff[FW-1:0] : cat[FW-1:0];
         quo_in[k]  = {quo_ff[k-1][QB-2:0], ge};
         low_in[k]  = {low_ff[k-1][QB-2:0], 1'b0};
         ovf_in[k]  = ovf_ff[k-1];
         zero_in[k] = zero_ff[k-1];
         neg_in[k]  = neg_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         low_ff  <= low_in;
         ovf_ff  <= ovf_in;
         zero_ff <= zero_in;
         neg_ff  <= neg_in;
      end
   end

   // apply sign and clamp to the output range
   always_comb begin
      quo_last = quo_ff[LAST];
      if (zero_ff[LAST]) begin
         result = '0;
      end else if (neg_ff[LAST]) begin
         if (ovf_ff[LAST] || (quo_last > bkp_pkg::OUT_NEG_MAG)) begin
            result = bkp_pkg::OUT_NEG_MAG;
         end else begin
            result = QB'(0) - quo_last;
         end
      end else begin
         if (ovf_ff[LAST] || (quo_last > bkp_pkg::OUT_POS_MAX)) begin
            result = bkp_pkg::OUT_POS_MAX;
         end else begin
            result = quo_last;
         end
      end
   end

endmodule

### hdl/bkp_back.sv
`timescale 1ns / 1ps

module bkp_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bkp_pkg::bkp_cfg_type               cfg,
   input  logic                               q_empty,
   input  logic [COORD_BITS-1:0]              q_row,
   input  logic [COORD_BITS-1:0]              q_col,
   input  logic [bkp_pkg::DEPTH_W-1:0]        q_depth,
   output logic                               q_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic signed [bkp_pkg::OUT_W-1:0]   point_x,
   output logic signed [bkp_pkg::OUT_W-1:0]   point_y,
   output logic [bkp_pkg::DEPTH_W-1:0]        point_z
);

   localparam int POS_W  = COORD_BITS + bkp_pkg::FRAC_BITS;
   localparam int MAG_W  = (POS_W > bkp_pkg::CENTER_W) ? POS_W : bkp_pkg::CENTER_W;
   localparam int PROD_W = MAG_W + bkp_pkg::DEPTH_W;
   localparam int LAST   = bkp_pkg::DIV_LAT - 1;

   logic                             adv;
   logic [MAG_W-1:0]                 pos_x, pos_y, cen_x, cen_y, mag_x, mag_y;
   logic                             neg_x, neg_y;

   logic                             m_valid_ff, m_valid_in;
   logic [MAG_W-1:0]                 m_mag_x_ff, m_mag_y_ff;
   logic                             m_neg_x_ff, m_neg_y_ff;
   logic [bkp_pkg::DEPTH_W-1:0]      m_depth_ff;

   logic                             p_valid_ff, p_valid_in;
   logic [PROD_W-1:0]                p_prod_x_ff, p_prod_y_ff;
   logic                             p_neg_x_ff, p_neg_y_ff;
   logic [bkp_pkg::DEPTH_W-1:0]      p_depth_ff;

   logic                             d_valid_ff [bkp_pkg::DIV_LAT];
   logic [bkp_pkg::DEPTH_W-1:0]      d_depth_ff [bkp_pkg::DIV_LAT];

   logic                             out_valid_ff, out_valid_in;
   logic signed [bkp_pkg::OUT_W-1:0] out_x_ff, out_y_ff;
   logic [bkp_pkg::DEPTH_W-1:0]      out_z_ff;
   logic signed [bkp_pkg::OUT_W-1:0] div_x, div_y;

   // the whole back pipeline advances whenever the output slot frees up
   assign adv   = !out_valid_ff || rsp_pop;
   assign q_pop = adv && !q_empty;

   assign pos_x = MAG_W'({q_col, {bkp_pkg::FRAC_BITS{1'b0}}});
   assign pos_y = MAG_W'({q_row, {bkp_pkg::FRAC_BITS{1'b0}}});
   assign cen_x = MAG_W'(cfg.principal_col);
   assign cen_y = MAG_W'(cfg.principal_row);
   assign neg_x = (pos_x < cen_x);
   assign neg_y = (pos_y < cen_y);
   assign mag_x = neg_x ? (cen_x - pos_x) : (pos_x - cen_x);
   assign mag_y = neg_y ? (cen_y - pos_y) : (pos_y - cen_y);

   always_comb begin
      m_valid_in   = m_valid_ff;
      p_valid_in   = p_valid_ff;
      out_valid_in = out_valid_ff;
      if (adv) begin
         m_valid_in   = !q_empty;
         p_valid_in   = m_valid_ff;
         out_valid_in = d_valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < bkp_pkg::DIV_LAT; k++) begin
            d_valid_ff[k] <= 1'b0;
         end
      end else begin
         m_valid_ff   <= m_valid_in;
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            d_valid_ff[0] <= p_valid_ff;
            for (int k = 1; k < bkp_pkg::DIV_LAT; k++) begin
               d_valid_ff[k] <= d_valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_mag_x_ff  <= mag_x;
         m_mag_y_ff  <= mag_y;
         m_neg_x_ff  <= neg_x;
         m_neg_y_ff  <= neg_y;
         m_depth_ff  <= q_depth;
         p_prod_x_ff <= PROD_W'(m_mag_x_ff) * PROD_W'(m_depth_ff);
         p_prod_y_ff <= PROD_W'(m_mag_y_ff) * PROD_W'(m_depth_ff);
         p_neg_x_ff  <= m_neg_x_ff;
         p_neg_y_ff  <= m_neg_y_ff;
         p_depth_ff  <= m_depth_ff;
         d_depth_ff[0] <= p_depth_ff;
         for (int k = 1; k < bkp_pkg::DIV_LAT; k++) begin
            d_depth_ff[k] <= d_depth_ff[k-1];
         end
         out_x_ff <= div_x;
         out_y_ff <= div_y;
         out_z_ff <= d_depth_ff[LAST];
      end
   end

   bkp_div #(.PROD_W(PROD_W)) u_div_x (
      .clock  (clock),
      .enable (adv),
      .focal  (cfg.focal_x),
      .prod   (p_prod_x_ff),
      .neg    (p_neg_x_ff),
      .result (div_x)
   );

   bkp_div #(.PROD_W(PROD_W)) u_div_y (
      .clock  (clock),
      .enable (adv),
      .focal  (cfg.focal_y),
      .prod   (p_prod_y_ff),
      .neg    (p_neg_y_ff),
      .result (div_y)
   );

   assign rsp_empty = !out_valid_ff;
   assign point_x   = out_x_ff;
   assign point_y   = out_y_ff;
   assign point_z   = out_z_ff;

endmodule

### hdl/depth_pixel_backprojection.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while the queue has room and the receiver pops;
// pixels outside the depth window give no point. Each point passes the input, depth,
// queue, offset and product registers, then the two division pipelines (a setup stage,
// then one quotient bit per stage over 22 stages), then the output register.
// Reset (synchronous, active high) empties the pipelines and the queue and loads
// the default camera and depth settings; it needs no clearing pass.
module depth_pixel_backprojection #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [COORD_BITS-1:0]                req_pixel_row,
   input  logic [COORD_BITS-1:0]                req_pixel_col,
   input  logic [bkp_pkg::RAW_W-1:0]            req_raw_depth,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [bkp_pkg::OUT_W-1:0]     rsp_point_x,
   output logic signed [bkp_pkg::OUT_W-1:0]     rsp_point_y,
   output logic [bkp_pkg::DEPTH_W-1:0]          rsp_point_z,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bkp_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [bkp_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [bkp_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int Q_W = 2 * COORD_BITS + bkp_pkg::DEPTH_W;

   bkp_pkg::bkp_cfg_type       cfg_ff, cfg_in;
   bkp_pkg::bkp_csr_index_type csr_index;
   logic                       csr_wr;

   logic                        q_push, q_full, q_pop, q_empty;
   logic [COORD_BITS-1:0]       f_row, f_col, b_row, b_col;
   logic [bkp_pkg::DEPTH_W-1:0] f_depth, b_depth;
   logic [Q_W-1:0]              q_head;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = bkp_pkg::bkp_csr_index_type'(csr_paddr[bkp_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_index)
            bkp_pkg::CSR_RAW_SCALE:     cfg_in.raw_scale = csr_pwdata;
            bkp_pkg::CSR_MIN_DEPTH:     cfg_in.min_depth = csr_pwdata;
            bkp_pkg::CSR_MAX_DEPTH:     cfg_in.max_depth = csr_pwdata;
            bkp_pkg::CSR_FOCAL_X:       cfg_in.focal_x   = csr_pwdata;
            bkp_pkg::CSR_FOCAL_Y:       cfg_in.focal_y   = csr_pwdata;
            bkp_pkg::CSR_PRINCIPAL_COL:
               cfg_in.principal_col = csr_pwdata[bkp_pkg::CENTER_W-1:0];
            bkp_pkg::CSR_PRINCIPAL_ROW:
               cfg_in.principal_row = csr_pwdata[bkp_pkg::CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bkp_pkg::CSR_RAW_SCALE:     csr_prdata = cfg_ff.raw_scale;
         bkp_pkg::CSR_MIN_DEPTH:     csr_prdata = cfg_ff.min_depth;
         bkp_pkg::CSR_MAX_DEPTH:     csr_prdata = cfg_ff.max_depth;
         bkp_pkg::CSR_FOCAL_X:       csr_prdata = cfg_ff.focal_x;
         bkp_pkg::CSR_FOCAL_Y:       csr_prdata = cfg_ff.focal_y;
         bkp_pkg::CSR_PRINCIPAL_COL: csr_prdata = bkp_pkg::CSR_DATA_W'(cfg_ff.principal_col);
         bkp_pkg::CSR_PRINCIPAL_ROW: csr_prdata = bkp_pkg::CSR_DATA_W'(cfg_ff.principal_row);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bkp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bkp_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .in_push (req_push),
      .in_full (req_full),
      .in_row  (req_pixel_row),
      .in_col  (req_pixel_col),
      .in_raw  (req_raw_depth),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_row   (f_row),
      .q_col   (f_col),
      .q_depth (f_depth)
   );

   bkp_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_row, f_col, f_depth}),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_head),
      .empty     (q_empty)
   );

   assign {b_row, b_col, b_depth} = q_head;

   bkp_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_row     (b_row),
      .q_col     (b_col),
      .q_depth   (b_depth),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .point_x   (rsp_point_x),
      .point_y   (rsp_point_y),
      .point_z   (rsp_point_z)
   );

endmodule

### hdl/bkp_checker.sv
`timescale 1ns / 1ps

module bkp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic signed [bkp_pkg::OUT_W-1:0]   rsp_point_x,
   input logic signed [bkp_pkg::OUT_W-1:0]   rsp_point_y,
   input logic [bkp_pkg::DEPTH_W-1:0]        rsp_point_z
);

   // no result is waiting on the output after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result present right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input blocked right after reset");

   // a delivered point passed the strict lower bound, so its depth is never zero
   a_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_point_z != '0))
      else $error("result with zero depth");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_point_z)))
      else $error("waiting result changed or vanished");

endmodule

bind depth_pixel_backprojection bkp_checker u_bkp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_full    (req_full),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_point_z (rsp_point_z)
);

### verif/depth_pixel_backprojection_checker.sv
`timescale 1ns / 1ps

module depth_pixel_backprojection_checker
   import bkp_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic                         req_full,
   input  logic [COORD_BITS-1:0]        req_pixel_row,
   input  logic [COORD_BITS-1:0]        req_pixel_col,
   input  logic [RAW_W-1:0]             req_raw_depth,
   input  logic                         rsp_empty,
   input  logic                         rsp_pop,
   input  logic signed [OUT_W-1:0]      rsp_point_x,
   input  logic signed [OUT_W-1:0]      rsp_point_y,
   input  logic [DEPTH_W-1:0]           rsp_point_z,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   input  logic                         csr_pready,
   output int                           pending_points,
   output int                           mismatch_count
);

   typedef struct packed {
      logic [OUT_W-1:0]   x;
      logic [OUT_W-1:0]   y;
      logic [DEPTH_W-1:0] z;
   } point_type;

   bkp_cfg_type camera;
   point_type   expected_points[$];

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   // raw reading times the Q0.32 scale, kept in Q16.16
   function automatic logic [DEPTH_W-1:0] scaled_depth(logic [RAW_W-1:0] raw,
                                                        logic [DEPTH_W-1:0] scale);
      logic [63:0] raw_wide;
      logic [63:0] scale_wide;
      logic [63:0] product;
      raw_wide   = raw;
      scale_wide = scale;
      product    = raw_wide * scale_wide;
      return product[FRAC_BITS +: DEPTH_W];
   endfunction

   // one pinhole coordinate: (index - center) * depth / focal, saturated
   function automatic logic [OUT_W-1:0] axis_coord(logic [COORD_BITS-1:0] index,
                                                    logic [CENTER_W-1:0] center,
                                                    logic [DEPTH_W-1:0] depth,
                                                    logic [FOCAL_W-1:0] focal);
      logic [63:0] pos;
      logic [63:0] ctr;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] quo;
      logic        neg;
      pos  = index;
      pos  = pos << FRAC_BITS;
      ctr  = center;
      neg  = pos < ctr;
      mag  = neg ? ctr - pos : pos - ctr;
      prod = mag * depth;
      if (prod == 0)
         quo = '0;
      else if (focal == 0)
         // a plain divider returns all ones on a zero divisor
         quo = '1;
      else
         quo = prod / focal;
      if (neg) begin
         if (quo > OUT_NEG_MAG)
            quo = OUT_NEG_MAG;
         quo = -quo;
      end else if (quo > OUT_POS_MAX) begin
         quo = OUT_POS_MAX;
      end
      return quo[OUT_W-1:0];
   endfunction

   always @(posedge clock) begin
      point_type          got;
      point_type          want;
      logic [DEPTH_W-1:0] depth;
      if (reset) begin
         camera = CFG_RESET;
         expected_points.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (bkp_csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               CSR_RAW_SCALE:     camera.raw_scale     = csr_pwdata;
               CSR_MIN_DEPTH:     camera.min_depth     = csr_pwdata;
               CSR_MAX_DEPTH:     camera.max_depth     = csr_pwdata;
               CSR_FOCAL_X:       camera.focal_x       = csr_pwdata;
               CSR_FOCAL_Y:       camera.focal_y       = csr_pwdata;
               CSR_PRINCIPAL_COL: camera.principal_col = csr_pwdata[CENTER_W-1:0];
               CSR_PRINCIPAL_ROW: camera.principal_row = csr_pwdata[CENTER_W-1:0];
               default: ;
            endcase
         end

         if (rsp_pop && !rsp_empty) begin
            got = '{x: rsp_point_x, y: rsp_point_y, z: rsp_point_z};
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("point with none expected: x=%0d y=%0d z=%0d",
                                         rsp_point_x, rsp_point_y, rsp_point_z));
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x)
                  report_mismatch($sformatf("point_x got %0d want %0d",
                                            $signed(got.x), $signed(want.x)));
               if (got.y !== want.y)
                  report_mismatch($sformatf("point_y got %0d want %0d",
                                            $signed(got.y), $signed(want.y)));
               if (got.z !== want.z)
                  report_mismatch($sformatf("point_z got %0d want %0d", got.z, want.z));
            end
         end

         if (req_push && !req_full) begin
            depth = scaled_depth(req_raw_depth, camera.raw_scale);
            // drop pixels outside the open depth window
            if (depth > camera.min_depth && depth < camera.max_depth) begin
               want = '{
                  x: axis_coord(req_pixel_col, camera.principal_col, depth, camera.focal_x),
                  y: axis_coord(req_pixel_row, camera.principal_row, depth, camera.focal_y),
                  z: depth
               };
               expected_points.insert(expected_points.size(), want);
            end
         end
      end
      pending_points <= expected_points.size();
   end

endmodule

### verif/tb_depth_pixel_backprojection.sv
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection;
   import bkp_pkg::*;

   localparam int COORD_BITS     = 12;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 400;
   localparam int STALL_LIMIT    = 3000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PRESSURE_PHASE = 3;
   localparam int PHASE_ITEMS    = 245;
   localparam int PRESSURE_ITEMS = 120;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                         clock;
   logic                         reset;
   logic                         req_push;
   logic                         req_full;
   logic [COORD_BITS-1:0]        req_pixel_row;
   logic [COORD_BITS-1:0]        req_pixel_col;
   logic [RAW_W-1:0]             req_raw_depth;
   logic                         rsp_empty;
   logic                         rsp_pop;
   logic signed [OUT_W-1:0]      rsp_point_x;
   logic signed [OUT_W-1:0]      rsp_point_y;
   logic [DEPTH_W-1:0]           rsp_point_z;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [CSR_ADDR_W-1:0]        csr_paddr;
   logic [CSR_DATA_W-1:0]        csr_pwdata;
   logic [CSR_DATA_W-1:0]        csr_prdata;
   logic                         csr_pready;

   logic tx_jitter;
   logic rx_jitter;
   int   hold_requests = 0;
   int   holds_served  = 0;
   int   pending_points;
   int   mismatch_count;
   int   quiet_cycles = 0;

   depth_pixel_backprojection #(
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_pixel_row (req_pixel_row),
      .req_pixel_col (req_pixel_col),
      .req_raw_depth (req_raw_depth),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   depth_pixel_backprojection_checker #(
      .COORD_BITS(COORD_BITS)
   ) point_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel_row  (req_pixel_row),
      .req_pixel_col  (req_pixel_col),
      .req_raw_depth  (req_raw_depth),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_z    (rsp_point_z),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .pending_points (pending_points),
      .mismatch_count (mismatch_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // end the run when no transaction of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no transaction in %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // point receiver: random stalls, plus one long hold-off on request
   initial begin : point_receiver
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (holds_served != hold_requests) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_served++;
         end else if (rx_jitter && $urandom_range(0, 9) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic send_pixel(logic [COORD_BITS-1:0] row, logic [COORD_BITS-1:0] col,
                             logic [RAW_W-1:0] raw);
      req_pixel_row <= row;
      req_pixel_col <= col;
      req_raw_depth <= raw;
      req_push      <= 1'b1;
      do @(posedge clock); while (req_full);
      if (tx_jitter && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_random_pixel(logic [RAW_W-1:0] raw_floor);
      send_pixel(COORD_BITS'($urandom_range(0, COORD_MAX)),
                 COORD_BITS'($urandom_range(0, COORD_MAX)),
                 RAW_W'($urandom_range(32'(raw_floor), 16'hFFFF)));
   endtask

   // wait for every expected point, then for the pipeline to run dry
   task automatic settle();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_points != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic configure(logic [31:0] scale, logic [31:0] min_d, logic [31:0] max_d,
                            logic [31:0] fx, logic [31:0] fy,
                            logic [31:0] cx, logic [31:0] cy);
      csr_write(CSR_RAW_SCALE, scale);
      csr_write(CSR_MIN_DEPTH, min_d);
      csr_write(CSR_MAX_DEPTH, max_d);
      csr_write(CSR_FOCAL_X, fx);
      csr_write(CSR_FOCAL_Y, fy);
      csr_write(CSR_PRINCIPAL_COL, cx);
      csr_write(CSR_PRINCIPAL_ROW, cy);
      // no register here: must leave the camera untouched
      csr_write(CSR_UNUSED, $urandom);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_camera();
      logic [31:0]     scale;
      logic [31:0]     lo;
      logic [31:0]     fx;
      logic [31:0]     fy;
      longint unsigned hi;
      case ($urandom_range(0, 3))
         0:       scale = $urandom_range(1 << 12, 32'hFFFF_FFFF);
         1:       scale = $urandom_range(1 << 12, 1 << 20);
         2:       scale = $urandom_range(1 << 20, 1 << 26);
         default: scale = CFG_RESET.raw_scale;
      endcase
      // deepest reachable depth sits just under the scale; open a window that starts inside it
      lo = $urandom_range(0, scale / 2);
      hi = {32'd0, lo};
      hi += $urandom_range(scale / 4, scale);
      if (hi > 64'hFFFF_FFFF)
         hi = 64'hFFFF_FFFF;
      fx = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(100 << 16, 2000 << 16);
      fy = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(100 << 16, 2000 << 16);
      configure(scale, lo, hi[31:0], fx, fy,
                $urandom_range(0, (1 << CENTER_W) - 1), $urandom_range(0, 1 << 28));
   endtask

   initial begin : stimulus
      logic last;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_pixel_row = '0;
      req_pixel_col = '0;
      req_raw_depth = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      tx_jitter     = 1'b1;
      rx_jitter     = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default camera: window 0.1 m to 2 m, principal point (320, 240)
      send_pixel(0, 0, 0);
      send_pixel(4095, 4095, 16'hFFFF);
      send_pixel(240, 320, 8000);
      send_pixel(0, 0, 8000);
      send_pixel(4095, 4095, 8000);
      send_pixel(0, 4095, 15999);
      send_pixel(4095, 0, 16000);
      send_pixel(100, 500, 800);
      send_pixel(2000, 3000, 801);

      // unit scale: depth equals the raw value, so the window edges are exact
      settle();
      configure(32'd65536, 32'd100, 32'd200, 600 << 16, 600 << 16, 320 << 16, 240 << 16);
      send_pixel(10, 10, 100);
      send_pixel(10, 20, 101);
      send_pixel(4095, 0, 199);
      send_pixel(0, 4095, 200);

      // register extremes; the center write carries bits above the register width
      settle();
      configure(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                32'd0, 32'hFFFF_FFFF);
      send_pixel(0, 0, 16'hFFFF);
      send_pixel(0, 4095, 16'hFFFF);
      send_pixel(4095, 1, 1);
      send_pixel(2048, 0, 0);
      send_pixel(4095, 4095, 16'h8000);

      // zero focal lengths saturate in the sign of the offset
      settle();
      configure(32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 320 << 16, 240 << 16);
      send_pixel(240, 320, 4000);
      send_pixel(0, 0, 4000);
      send_pixel(4095, 4095, 16'hFFFF);
      send_pixel(240, 0, 1);

      // empty window: every pixel is dropped
      settle();
      configure(32'd65536, 32'd5000, 32'd5000, 600 << 16, 600 << 16, 320 << 16, 240 << 16);
      send_pixel(5, 5, 5000);
      send_pixel(6, 6, 5001);
      send_pixel(7, 7, 4999);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         last      = (phase == RANDOM_PHASES - 1);
         tx_jitter = !last && phase != 1 && phase != PRESSURE_PHASE;
         rx_jitter = !last && phase != 2;
         if (phase == PRESSURE_PHASE) begin
            // every nonzero pixel yields a point; stall the receiver so the block backs up
            configure(32'd65536, 32'd0, 32'hFFFF_FFFF, $urandom_range(1 << 16, 32'hFFFF_FFFF),
                      $urandom_range(1 << 16, 32'hFFFF_FFFF), $urandom_range(0, 1 << 28),
                      $urandom_range(0, 1 << 28));
            hold_requests++;
            repeat (PRESSURE_ITEMS) send_random_pixel(1);
         end else begin
            random_camera();
            repeat (PHASE_ITEMS) send_random_pixel(0);
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
